// File: rtl/amdds_pkg.sv
// Package: constants and widths shared by the millivolt display scan.
package amdds_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int FS_W     = 14;
    localparam int PROD_W   = SAMPLE_W + FS_W;
    localparam int MV_W     = 14;
    localparam int COMB_W   = 28;
    localparam int VAL_W    = 27;
    localparam int POS_W    = 3;
    localparam int DIGIT_W  = 4;
    localparam int WORD_W   = POS_W + DIGIT_W;

    // Display geometry
    localparam int NUM_DIGITS = 8;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

    // Arithmetic constants
    localparam logic [FS_W-1:0]    FULL_SCALE_RESET = 14'd3300;
    localparam logic [12:0]        ADC_MAX_CODE     = 13'd4095;
    localparam logic [COMB_W-1:0]  MV_WEIGHT        = 28'd10000;
    localparam logic [COMB_W-1:0]  DISPLAY_MODULUS  = 28'd100000000;
    // floor(x / 10) = (x * DIV10_MAGIC) >> DIV10_SHIFT for any x below 2^32
    localparam logic [31:0]        DIV10_MAGIC      = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT      = 35;

endpackage

// File: rtl/adc_millivolt_decimal_display_scan.sv
// Top level: ADC sample to millivolts, then an eight-digit decimal display scan.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready       | tdata[11:0] adc_sample
//  m_axis    | out       | m_axis_tvalid/tready       | tdata port_word, position, digit;
//            |           |                            | tlast last_digit
//  cfg       | in        | cfg_valid/cfg_ready        | cfg_data[13:0] full_scale_mv
//
// Four register stages (multiply, divide by 4095, scale and add, wrap to eight digits)
// feed a digit unit that emits one word per cycle unless m_axis stalls, eight words
// per sample; the digit unit is the throughput limit, and a new sample can be loaded
// in the cycle its last word leaves. Reset clears all valid bits and sets full scale
// to 3300 mV. Back-pressure on m_axis stalls the digit unit and then the stages in
// turn; nothing is dropped.
module adc_millivolt_decimal_display_scan
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data,        // [13:0] full_scale_mv
    // sample input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [11:0] adc_sample, [15:12] unused
    // digit output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [6:0] port_word, [9:7] digit_position,
                                         // [13:10] digit_value, [15:14] zero
    output logic        m_axis_tlast     // last_digit
);
    import amdds_pkg::*;

    // Configuration register
    logic [FS_W-1:0] fs_reg;

    // Stage 1: product
    logic                s1_valid_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    // Stage 2: millivolts
    logic                s2_valid_reg;
    logic [MV_W-1:0]     s2_mv_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;
    // Stage 3: combined value
    logic                s3_valid_reg;
    logic [COMB_W-1:0]   s3_comb_reg;
    // Stage 4: value below 10^8
    logic                s4_valid_reg;
    logic [VAL_W-1:0]    s4_val_reg;
    // Digit unit
    logic                busy_reg;
    logic [VAL_W-1:0]    rest_reg;
    logic [POS_W-1:0]    pos_reg;
    // Output register
    logic                out_valid_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [DIGIT_W-1:0]  out_digit_reg;
    logic                out_last_reg;

    // Stage handshakes
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic out_go, step, unit_free, load;

    // Datapath
    logic [PROD_W-1:0]   prod_next;
    logic [MV_W-1:0]     q0;
    logic [11:0]         rem_a;
    logic [14:0]         r1;
    logic [2:0]          q1;
    logic [12:0]         r2;
    logic                corr;
    logic [MV_W-1:0]     mv_next;
    logic [COMB_W-1:0]   comb_next;
    logic [VAL_W-1:0]    val_next;
    logic [63:0]         div_prod;
    logic [VAL_W-1:0]    quo;
    logic [VAL_W-1:0]    dig_full;
    logic [DIGIT_W-1:0]  digit;

    // Hold full scale; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FULL_SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            fs_reg <= cfg_data;
        end
    end

    // Ready chain from the digit unit back to the input
    assign out_go        = !out_valid_reg || m_axis_tready;
    assign step          = busy_reg && out_go;
    assign unit_free     = !busy_reg || (step && (pos_reg == POS_LAST));
    assign load          = s4_valid_reg && unit_free;
    assign s4_ready      = !s4_valid_reg || unit_free;
    assign s3_ready      = !s3_valid_reg || s4_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    // Stage 1: sample times full scale
    assign prod_next = PROD_W'(s_axis_tdata[SAMPLE_W-1:0]) * PROD_W'(fs_reg);

    // Stage 2: divide by 4095 using 4096 = 4095 + 1, folded twice then corrected once
    always_comb
    begin
        q0      = s1_prod_reg[PROD_W-1:12];
        rem_a   = s1_prod_reg[11:0];
        r1      = 15'(rem_a) + 15'(q0);
        q1      = r1[14:12];
        r2      = 13'(r1[11:0]) + 13'(q1);
        corr    = (r2 >= ADC_MAX_CODE);
        mv_next = q0 + MV_W'(q1) + MV_W'(corr);
    end

    // Stage 3: millivolts in the upper four digits, raw sample below
    assign comb_next = COMB_W'(s2_mv_reg) * MV_WEIGHT + COMB_W'(s2_sample_reg);

    // Stage 4: keep eight decimal digits; the value stays below twice the modulus
    assign val_next = (s3_comb_reg >= DISPLAY_MODULUS) ?
                      VAL_W'(s3_comb_reg - DISPLAY_MODULUS) : VAL_W'(s3_comb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Advance payload with each stage
    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_prod_reg   <= prod_next;
            s1_sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_mv_reg     <= mv_next;
            s2_sample_reg <= s1_sample_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_comb_reg <= comb_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_val_reg <= val_next;
        end
    end

    // Digit unit: peel one decimal digit per word, lowest first
    always_comb
    begin
        div_prod = 64'(rest_reg) * 64'(DIV10_MAGIC);
        quo      = div_prod[DIV10_SHIFT + VAL_W - 1:DIV10_SHIFT];
        dig_full = rest_reg - ((quo << 3) + (quo << 1));
        digit    = dig_full[DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (step)
            begin
                busy_reg <= (pos_reg != POS_LAST);
                pos_reg  <= pos_reg + POS_W'(1);
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rest_reg <= s4_val_reg;
        end
        else if (step)
        begin
            rest_reg <= quo;
        end
        if (step)
        begin
            out_pos_reg   <= pos_reg;
            out_digit_reg <= digit;
            out_last_reg  <= (pos_reg == POS_LAST);
        end
    end

    // Drive the output word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_digit_reg, out_pos_reg,
                            WORD_W'({out_pos_reg, out_digit_reg})};

    // Checks
    a_last_on_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_pos_reg == POS_LAST)))
        else $error("last flag does not match top digit position");

    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_digit_reg <= DIGIT_W'(9)))
        else $error("digit out of decimal range");

    a_value_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (COMB_W'(s4_val_reg) < DISPLAY_MODULUS))
        else $error("stage four value not below modulus");

    a_unit_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(pos_reg) == POS_LAST))
        else $error("digit unit stopped before the last digit");

    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && load) |=> (pos_reg == '0))
        else $error("new sample loaded but position not restarted");

endmodule
